FILE: design/thumbstick_radial_deadzone_macros.svh
// Assertion macros for the thumbstick deadzone design files; tsrd_fifo uses them.
`ifndef THUMBSTICK_RADIAL_DEADZONE_MACROS_SVH
`define THUMBSTICK_RADIAL_DEADZONE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSRD_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define TSRD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define TSRD_ASSERT(lbl, ck, rs, prop, msg)
`define TSRD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

FILE: design/tsrd_pkg.sv
// Shared constants and types for the thumbstick radial deadzone.
package tsrd_pkg;
  localparam int STICK_W = 16;
  localparam int DZ_W = 15;
  localparam int SQ_W = 32;
  localparam int SCALE_BITS = 15;
  localparam int FULL_SCALE = 32767;
  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic signed [STICK_W-1:0] x;
    logic signed [STICK_W-1:0] y;
    logic [SQ_W-1:0]           sq;
    logic                      in_dz;
  } front_item_t;
endpackage

FILE: design/tsrd_front.sv
// Front end: squares the sample, sums and classifies against the deadzone circle.
module tsrd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tsrd_pkg::DZ_W-1:0]           dz,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tsrd_pkg::STICK_W-1:0] in_x,
  input  logic signed [tsrd_pkg::STICK_W-1:0] in_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tsrd_pkg::front_item_t               out_item
);
  logic                                adv;
  logic                                v1;
  logic signed [tsrd_pkg::STICK_W-1:0] x1, y1;
  logic [30:0]                         sqx1, sqy1;
  logic signed [31:0]                  px, py;
  logic [29:0]                         dz_sq;
  logic [tsrd_pkg::SQ_W-1:0]           sum;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign px       = in_x * in_x;
  assign py       = in_y * in_y;
  assign sum      = {1'b0, sqx1} + {1'b0, sqy1};

  always_ff @(posedge clk) begin
    dz_sq <= 30'(dz) * 30'(dz);
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
    if (adv) begin
      x1             <= in_x;
      y1             <= in_y;
      sqx1           <= px[30:0];
      sqy1           <= py[30:0];
      out_item.x     <= x1;
      out_item.y     <= y1;
      out_item.sq    <= sum;
      out_item.in_dz <= sum < {2'b00, dz_sq};
    end
  end
endmodule

FILE: design/tsrd_fifo.sv
// Short queue between the classifier and the magnitude/scale back end.
`include "thumbstick_radial_deadzone_macros.svh"
module tsrd_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tsrd_pkg::front_item_t push_item,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output tsrd_pkg::front_item_t head
);
  localparam int AW = $clog2(tsrd_pkg::QDEPTH);

  tsrd_pkg::front_item_t mem [tsrd_pkg::QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(tsrd_pkg::QDEPTH);
  assign empty = count == '0;
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= push_item;
  end

  `TSRD_ASSERT(a_count_bound, clk, rst, count <= (AW+1)'(tsrd_pkg::QDEPTH), "queue overfilled")
  `TSRD_ASSERT(a_no_pop_empty, clk, rst, !(pop && empty), "pop from empty queue")
  `TSRD_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + 1'b1, "count lost a push")
endmodule

FILE: design/tsrd_sqrt.sv
// Pipelined bit-per-stage integer square root of the fixed-point squared length.
module tsrd_sqrt #(
  parameter int FRAC_BITS = tsrd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  tsrd_pkg::front_item_t        in_item,
  output logic                         out_valid,
  output tsrd_pkg::front_item_t        out_item,
  output logic [16+FRAC_BITS-1:0]      out_root
);
  localparam int RW  = 16 + FRAC_BITS;
  localparam int SQW = 2 * RW;

  logic [RW:0]           vld;
  tsrd_pkg::front_item_t itm  [RW+1];
  logic [RW+1:0]         rem  [RW+1];
  logic [RW-1:0]         root [RW+1];

  assign vld[0]  = in_valid;
  assign itm[0]  = in_item;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [SQW-1:0] v;
    logic [RW+1:0]  rsh, t;
    logic           ge;
    assign v   = SQW'(itm[k].sq) << (2 * FRAC_BITS);
    assign rsh = {rem[k][RW-1:0], v[2*(RW-1-k) +: 2]};
    assign t   = {root[k], 2'b01};
    assign ge  = rsh >= t;
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
      if (en) begin
        itm[k+1]  <= itm[k];
        rem[k+1]  <= ge ? rsh - t : rsh;
        root[k+1] <= {root[k][RW-2:0], ge};
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_item  = itm[RW];
  assign out_root  = root[RW];
endmodule

FILE: design/tsrd_scale.sv
// Back end: rescale factor, per-axis restoring divide, saturation, output register.
module tsrd_scale #(
  parameter int FRAC_BITS = tsrd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tsrd_pkg::DZ_W-1:0]           dz,
  output logic                                advance,
  input  logic                                in_valid,
  input  tsrd_pkg::front_item_t               in_item,
  input  logic [16+FRAC_BITS-1:0]             in_root,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tsrd_pkg::STICK_W-1:0] out_x,
  output logic signed [tsrd_pkg::STICK_W-1:0] out_y,
  output logic                                out_dz
);
  localparam int RW = 16 + FRAC_BITS;
  localparam int SB = tsrd_pkg::SCALE_BITS;
  localparam int DW = RW + SB;
  localparam int PW = RW + 16;
  localparam int NW = RW + 2 * SB + 1;

  typedef struct packed {
    logic          negx, negy, zx, zy, sx, sy, in_dz;
    logic [NW-1:0] rx, ry;
    logic [SB-1:0] qx, qy;
    logic [DW-1:0] den;
  } div_t;

  // stage A
  logic          a_v, a_negx, a_negy, a_in;
  logic [15:0]   a_mx, a_my;
  logic [RW-1:0] a_num, edge_fx, num_c;
  logic [DW-1:0] a_den;
  // stage B
  logic          b_v, b_negx, b_negy, b_in, b_zx, b_zy;
  logic [PW-1:0] b_px, b_py;
  logic [DW-1:0] b_den;
  logic [NW-1:0] nx, ny, dsh;
  // divider
  logic [SB:0]   dvv;
  div_t          dv [SB+1];

  assign advance = !out_valid || out_ready;
  assign edge_fx = RW'(dz) << FRAC_BITS;
  assign num_c   = (in_root > edge_fx) ? in_root - edge_fx : '0;

  assign nx  = (NW'(b_px) << SB) - NW'(b_px);
  assign ny  = (NW'(b_py) << SB) - NW'(b_py);
  assign dsh = NW'(b_den) << SB;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else if (advance) begin
      a_v <= in_valid;
      b_v <= a_v;
    end
    if (advance) begin
      a_negx <= in_item.x[15];
      a_negy <= in_item.y[15];
      a_mx   <= in_item.x[15] ? 16'(16'sd0 - in_item.x) : in_item.x;
      a_my   <= in_item.y[15] ? 16'(16'sd0 - in_item.y) : in_item.y;
      a_in   <= in_item.in_dz;
      a_num  <= num_c;
      a_den  <= DW'(in_root) * DW'(15'(tsrd_pkg::FULL_SCALE) - dz);
      b_negx <= a_negx;
      b_negy <= a_negy;
      b_in   <= a_in;
      b_zx   <= a_in || a_mx == '0 || a_num == '0;
      b_zy   <= a_in || a_my == '0 || a_num == '0;
      b_px   <= PW'(a_num) * PW'(a_mx);
      b_py   <= PW'(a_num) * PW'(a_my);
      b_den  <= a_den;
    end
  end

  assign dvv[0]      = b_v;
  assign dv[0].negx  = b_negx;
  assign dv[0].negy  = b_negy;
  assign dv[0].zx    = b_zx;
  assign dv[0].zy    = b_zy;
  assign dv[0].sx    = nx >= dsh;
  assign dv[0].sy    = ny >= dsh;
  assign dv[0].in_dz = b_in;
  assign dv[0].rx    = nx;
  assign dv[0].ry    = ny;
  assign dv[0].qx    = '0;
  assign dv[0].qy    = '0;
  assign dv[0].den   = b_den;

  // one quotient bit per stage, MSB first
  for (genvar i = 0; i < SB; i++) begin : g_div
    localparam int J = SB - 1 - i;
    logic [NW-1:0] sh;
    logic          gx, gy;
    div_t          nxt;
    assign sh = NW'(dv[i].den) << J;
    assign gx = dv[i].rx >= sh;
    assign gy = dv[i].ry >= sh;
    always_comb begin
      nxt    = dv[i];
      nxt.rx = gx ? dv[i].rx - sh : dv[i].rx;
      nxt.ry = gy ? dv[i].ry - sh : dv[i].ry;
      nxt.qx = {dv[i].qx[SB-2:0], gx};
      nxt.qy = {dv[i].qy[SB-2:0], gy};
    end
    always_ff @(posedge clk) begin
      if (rst) dvv[i+1] <= 1'b0;
      else if (advance) dvv[i+1] <= dvv[i];
      if (advance) dv[i+1] <= nxt;
    end
  end

  function automatic logic signed [15:0] finish(input logic neg, input logic z,
                                                input logic s, input logic [SB-1:0] q);
    logic signed [15:0] r;
    if (z)        r = '0;
    else if (s)   r = neg ? 16'sh8000 : 16'sh7fff;
    else if (neg) r = 16'(16'sd0 - {1'b0, q});
    else          r = {1'b0, q};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= dvv[SB];
    if (advance) begin
      out_x  <= finish(dv[SB].negx, dv[SB].zx, dv[SB].sx, dv[SB].qx);
      out_y  <= finish(dv[SB].negy, dv[SB].zy, dv[SB].sy, dv[SB].qy);
      out_dz <= dv[SB].in_dz;
    end
  end
endmodule

FILE: design/thumbstick_radial_deadzone.sv
// Top level of the thumbstick radial deadzone with rescaling.
// Takes one signed (x, y) stick sample per transfer and returns one transfer
// per sample, in order. Samples inside the dead_zone circle give (0, 0) with
// tuser[0] set; others are rescaled along their radius so the circle edge maps
// to 0 and full deflection to 32767, truncated toward zero and saturated.
// Throughput is one sample per clock with no bubbles while the output side
// accepts. A sample passes the front squares/compare registers, the queue,
// the square root (one root bit per stage), the scale multiplies, the divide
// (one quotient bit per divide stage) and the output register; an output
// stall holds it in place; the 4-entry queue lets the front keep accepting
// while the back end stalls, until the queue is full.
// Write dead_zone only while no sample is in flight.
module thumbstick_radial_deadzone #(
  parameter int FRAC_BITS = tsrd_pkg::FRAC_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,    // dead_zone
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] stick_x, [31:16] stick_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_x, [31:16] out_y
  output logic [0:0]  m_axis_tuser    // [0] in_dead_zone
);
  logic [tsrd_pkg::DZ_W-1:0] dead_zone;

  always_ff @(posedge clk) begin
    if (rst) dead_zone <= '0;
    else if (cfg_wr_en) dead_zone <= cfg_wr_data;
  end

  logic                  f_valid, q_full, q_empty, advance, f_ready;
  tsrd_pkg::front_item_t f_item, q_head, s_item;
  logic                  s_valid;
  logic [16+FRAC_BITS-1:0] s_root;
  logic signed [15:0]    ox, oy;

  tsrd_front u_front (
    .clk, .rst, .dz(dead_zone),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_x(s_axis_tdata[15:0]), .in_y(s_axis_tdata[31:16]),
    .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
  );

  assign f_ready = !q_full;

  tsrd_fifo u_fifo (
    .clk, .rst,
    .push(f_valid && !q_full), .push_item(f_item), .full(q_full),
    .pop(advance && !q_empty), .empty(q_empty), .head(q_head)
  );

  tsrd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk, .rst, .en(advance),
    .in_valid(!q_empty), .in_item(q_head),
    .out_valid(s_valid), .out_item(s_item), .out_root(s_root)
  );

  tsrd_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk, .rst, .dz(dead_zone), .advance,
    .in_valid(s_valid), .in_item(s_item), .in_root(s_root),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_x(ox), .out_y(oy), .out_dz(m_axis_tuser[0])
  );

  assign m_axis_tdata = {oy, ox};
endmodule

FILE: dv/tb_thumbstick_radial_deadzone.sv
// Testbench for the thumbstick radial deadzone: directed table plus random samples, scoreboarded.
module tb_thumbstick_radial_deadzone;
  localparam int FRAC = 8;
  localparam int LATENCY = 45;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               dead;
  } stick_result_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 known;    // expected result typed in the table
    stick_result_t      res;
  } sample_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [15:0] stick_x, [31:16] stick_y
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [15:0] out_x, [31:16] out_y
  logic [0:0]  m_axis_tuser;        // [0] in_dead_zone

  thumbstick_radial_deadzone #(.FRAC_BITS(FRAC)) uut (.*);

  always #1 clk = ~clk;

  logic [14:0]   dz_radius = '0;    // predictor's copy of dead_zone
  stick_result_t expected_q[$];
  int            errors = 0;
  int            idle_cycles = 0;
  bit            hold_rx = 1'b0;
  bit            calm = 1'b0;       // no idling at all
  bit            done = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] rescale(logic signed [15:0] c, logic [63:0] num,
                                                 logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-int'(c)) : 64'(c);
    if (mag == 0 || num == 0) return '0;
    q = (den == 0) ? ((c < 0) ? 64'd32768 : 64'd32767) : (num * 64'd32767 * mag) / den;
    if (c < 0) begin
      if (q > 64'd32768) q = 64'd32768;
      return 16'(-q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return 16'(q);
  endfunction

  function automatic stick_result_t predict_deadzone(logic signed [15:0] x,
                                                     logic signed [15:0] y);
    stick_result_t r;
    logic [63:0] sq;
    logic [63:0] d;
    logic [63:0] edge_fx;
    logic [63:0] num;
    logic [63:0] den;
    r = '0;
    sq = 64'(int'(x) * int'(x)) + 64'(int'(y) * int'(y));
    if (sq < 64'(dz_radius) * 64'(dz_radius)) begin
      r.dead = 1'b1;
      return r;
    end
    d = int_sqrt(sq << (2 * FRAC));
    edge_fx = 64'(dz_radius) << FRAC;
    num = (d > edge_fx) ? d - edge_fx : '0;
    den = d * (64'd32767 - 64'(dz_radius));
    if (d != 0) begin
      r.x = rescale(x, num, den);
      r.y = rescale(y, num, den);
    end
    return r;
  endfunction

  // single transfer on the sample side; random gaps unless calm, valid stays up back to back
  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y, bit known,
                             stick_result_t res);
    while (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(known ? res : predict_deadzone(x, y));
    @(negedge clk);
  endtask

  task automatic drain_and_write(logic [14:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    dz_radius = value;
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  // result side: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !hold_rx && (calm || $urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    stick_result_t got;
    stick_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[0]};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d dead=%0b", $time, got.x, got.y, got.dead);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.dead !== want.dead) begin
          $display("%0t: mismatch expected x=%0d y=%0d dead=%0b actual x=%0d y=%0d dead=%0b",
                   $time, want.x, want.y, want.dead, got.x, got.y, got.dead);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[thumbstick_radial_deadzone] ERROR");
      $finish;
    end
  end

  initial begin
    sample_row_t table_rows[$];
    stick_result_t zero_dead;
    stick_result_t zero_live;
    logic [14:0] settings[6];
    zero_dead = '{x: 16'sd0, y: 16'sd0, dead: 1'b1};
    zero_live = '0;
    settings = '{15'd0, 15'd32766, 15'd8000, 15'd1, 15'd20000, 15'd32767};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // dead_zone 0 after reset: zero length, extremes, axes
    table_rows = '{
      '{16'sd0, 16'sd0, 1'b1, zero_live},
      '{16'sh7FFF, 16'sd0, 1'b1, '{16'sh7FFF, 16'sd0, 1'b0}},
      '{16'sh8000, 16'sd0, 1'b1, '{16'sh8000, 16'sd0, 1'b0}},
      '{16'sd0, 16'sh7FFF, 1'b1, '{16'sd0, 16'sh7FFF, 1'b0}},
      '{16'sd0, 16'sh8000, 1'b1, '{16'sd0, 16'sh8000, 1'b0}},
      '{16'sh8000, 16'sh8000, 1'b0, zero_live},
      '{16'sh7FFF, 16'sh7FFF, 1'b0, zero_live},
      '{16'sd1, 16'sd1, 1'b0, zero_live},
      '{16'sh5555, 16'shAAAA, 1'b0, zero_live}
    };
    foreach (table_rows[i])
      send_sample(table_rows[i].x, table_rows[i].y, table_rows[i].known, table_rows[i].res);

    // deadzone 100: inside, on the edge, just outside
    drain_and_write(15'd100);
    table_rows = '{
      '{16'sd0, 16'sd0, 1'b1, zero_dead},
      '{16'sd99, 16'sd0, 1'b1, zero_dead},
      '{16'sd100, 16'sd0, 1'b1, zero_live},
      '{16'sd60, -16'sd80, 1'b1, zero_live},
      '{16'sd0, -16'sd100, 1'b1, zero_live},
      '{16'sd101, 16'sd0, 1'b0, zero_live},
      '{-16'sd70, 16'sd71, 1'b0, zero_live},
      '{16'sh8000, 16'sd5, 1'b0, zero_live}
    };
    foreach (table_rows[i])
      send_sample(table_rows[i].x, table_rows[i].y, table_rows[i].known, table_rows[i].res);

    // full-radius register: divisor zero, components saturate by sign
    drain_and_write(15'd32767);
    table_rows = '{
      '{16'sh7FFF, 16'sd0, 1'b1, zero_live},
      '{16'sh7FFF, 16'sh7FFF, 1'b1, '{16'sh7FFF, 16'sh7FFF, 1'b0}},
      '{16'sh8000, 16'sd0, 1'b1, '{16'sh8000, 16'sd0, 1'b0}},
      '{16'sd10, 16'sd10, 1'b1, zero_dead}
    };
    foreach (table_rows[i])
      send_sample(table_rows[i].x, table_rows[i].y, table_rows[i].known, table_rows[i].res);

    // random phases over several deadzone settings
    foreach (settings[s]) begin
      drain_and_write(s == 2 ? 15'($urandom_range(0, 32766)) : settings[s]);
      calm = (s == 1);
      if (s == 3) fork
        begin
          hold_rx = 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_rx = 1'b0;
        end
      join_none
      for (int n = 0; n < 330; n++) begin
        logic signed [15:0] x;
        logic signed [15:0] y;
        x = rand_axis();
        y = rand_axis();
        send_sample(x, y, 1'b0, zero_live);
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    done = 1'b1;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("[thumbstick_radial_deadzone] OK");
    else $display("[thumbstick_radial_deadzone] ERROR");
    $finish;
  end

  // final-phase watchdog while draining
  initial begin
    wait (done);
    repeat (WATCHDOG_LIMIT) @(posedge clk);
    $display("[thumbstick_radial_deadzone] ERROR");
    $finish;
  end
endmodule
